// File: sv/qrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

	// register byte addresses (index * 4)
	localparam logic [4:0] REG_ORIGIN_X   = 5'd0;
	localparam logic [4:0] REG_ORIGIN_Y   = 5'd4;
	localparam logic [4:0] REG_RESOLUTION = 5'd8;
	localparam logic [4:0] REG_OUT_WIDTH  = 5'd12;
	localparam logic [4:0] REG_OUT_HEIGHT = 5'd16;
	localparam logic [4:0] REG_MODE       = 5'd20;
	localparam logic [4:0] REG_NODATA     = 5'd24;

	localparam int unsigned DIV_W  = 40;  // dividend magnitude bits
	localparam int unsigned DCNT_W = 6;   // divider step counter
	localparam logic [15:0] RASTER_MAX = 16'd32768;

	typedef struct packed {
		logic signed [31:0] corner0_x;
		logic signed [31:0] corner0_y;
		logic signed [31:0] corner1_x;
		logic signed [31:0] corner1_y;
		logic signed [31:0] corner2_x;
		logic signed [31:0] corner2_y;
		logic signed [31:0] corner3_x;
		logic signed [31:0] corner3_y;
		logic signed [31:0] value0;
		logic signed [31:0] value1;
		logic signed [31:0] value2;
		logic signed [31:0] value3;
	} quad_t;

	typedef struct packed {
		logic [14:0]        pixel_x;
		logic [14:0]        pixel_y;
		logic signed [31:0] pixel_value;
		logic               last;
		logic               out_of_bounds;
		logic               size_clamped;
	} pixel_t;

endpackage
`default_nettype wire

// File: sv/quad_resample_splat_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Splats one projected quad onto an output raster. A quad transaction (four
// Q24.8 corners, four samples) is taken only while the block is idle; the
// block then sizes a q-by-q grid (q = 2 + floor(max edge / resolution), at
// least 2, clamped to MAX_GRID with size_clamped set), subdivides the edges
// and emits one pixel transaction per grid point in row-major order, last on
// the final one. A point outside the raster ends the quad with a single
// out_of_bounds pixel (last set, coordinates and value zero). All divisions (edge
// rounding, cell index, bilinear normalization) run through one shared
// restoring divider that retires one quotient bit per cycle. Work per quad:
// edge measurement and sizing, 4 divisions at the start of each row, then
// per pixel 4 divisions (5 plus the BTOP, BBOT and BSUM multiply states in
// bilinear mode with no nodata sample) and the output, which waits for
// out_ready.
// Configuration goes through the APB port and must only be written while
// the block is idle; pready is tied high.
module quad_resample_splat_top
	import qrs_pkg::*;
#(
	parameter int unsigned MAX_GRID        = 8,
	parameter int unsigned COORD_FRAC_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire quad_t       in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output pixel_t           out_data
);

	localparam int unsigned QW = $clog2(MAX_GRID + 1);
	localparam logic [QW-1:0] QMAX = QW'(MAX_GRID);
	localparam logic [30:0] RES_ONE = 31'(1) << COORD_FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_EDGE, S_SIZE, S_LAUNCH, S_DIV, S_FIN,
		S_BTOP, S_BBOT, S_BSUM, S_OUT
	} state_t;

	typedef enum logic [3:0] {
		J_LX, J_LY, J_RX, J_RY, J_PX, J_PY, J_IX, J_IY, J_BL
	} job_t;

	// ---------------- configuration registers ----------------
	logic signed [31:0] origin_x_q, origin_y_q, nodata_q;
	logic [30:0]        resolution_q;
	logic [15:0]        out_width_q, out_height_q;
	logic               mode_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			resolution_q <= 31'd256;
			out_width_q  <= 16'd1024;
			out_height_q <= 16'd1024;
			mode_q       <= 1'b0;
			nodata_q     <= '0;
		end else if (wr_en) begin
			unique case (paddr)
				REG_ORIGIN_X:   origin_x_q   <= pwdata;
				REG_ORIGIN_Y:   origin_y_q   <= pwdata;
				REG_RESOLUTION: resolution_q <= pwdata[30:0];
				REG_OUT_WIDTH:  out_width_q  <= pwdata[15:0];
				REG_OUT_HEIGHT: out_height_q <= pwdata[15:0];
				REG_MODE:       mode_q       <= pwdata[0];
				REG_NODATA:     nodata_q     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			REG_ORIGIN_X:   prdata = origin_x_q;
			REG_ORIGIN_Y:   prdata = origin_y_q;
			REG_RESOLUTION: prdata = {1'b0, resolution_q};
			REG_OUT_WIDTH:  prdata = {16'd0, out_width_q};
			REG_OUT_HEIGHT: prdata = {16'd0, out_height_q};
			REG_MODE:       prdata = {31'd0, mode_q};
			REG_NODATA:     prdata = nodata_q;
			default:        prdata = '0;
		endcase
	end

	// effective resolution and raster limits
	logic [30:0] res_eff;
	logic [15:0] wlim, hlim;
	assign res_eff = (resolution_q < RES_ONE) ? RES_ONE : resolution_q;
	assign wlim    = (out_width_q > RASTER_MAX) ? RASTER_MAX : out_width_q;
	assign hlim    = (out_height_q > RASTER_MAX) ? RASTER_MAX : out_height_q;

	// ---------------- sequencer state ----------------
	state_t state_q;
	job_t   job_q;

	// corners held in a rotating line; slot 0/1 are the edge being measured
	logic signed [31:0] cx_q [4];
	logic signed [31:0] cy_q [4];
	logic signed [31:0] v_q  [4];
	logic [1:0]         ecnt_q;
	logic [31:0]        mw_q, mh_q;
	logic [34:0]        acc_q;
	logic [QW-1:0]      q_q, row_q, col_q;
	logic               clamp_q, near_q;
	logic signed [31:0] lx_q, ly_q, rx_q, ry_q, px_q, py_q;
	logic [14:0]        ix_q, iy_q;
	logic               oobx_q;
	logic signed [36:0] top_q, bot_q;
	logic signed [40:0] bsum_q;

	// shared divider
	logic [DIV_W-1:0]  dq_q;
	logic [31:0]       rem_q;
	logic [30:0]       vsr_q;
	logic              neg_q;
	logic [DCNT_W-1:0] dcnt_q;

	pixel_t out_q;
	logic   ovalid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovalid_q;
	assign out_data  = out_q;

	// edge measurement
	logic [32:0] ex_d, ey_d;
	logic [31:0] ex_abs, ey_abs, mm;
	assign ex_d   = 33'(cx_q[1]) - 33'(cx_q[0]);
	assign ey_d   = 33'(cy_q[1]) - 33'(cy_q[0]);
	assign ex_abs = ex_d[32] ? 32'(-ex_d) : ex_d[31:0];
	assign ey_abs = ey_d[32] ? 32'(-ey_d) : ey_d[31:0];
	assign mm     = (mw_q > mh_q) ? mw_q : mh_q;

	// operand selection for the current job
	logic signed [31:0] la, lb;
	logic [QW-1:0]      li;
	logic [QW-1:0]      nn;
	logic signed [40:0] diff, lnum, num;
	logic [30:0]        den;
	logic [DIV_W-1:0]   mag;

	assign nn = q_q - QW'(1);

	always_comb begin
		la = cx_q[0];
		lb = cx_q[3];
		li = row_q;
		case (job_q)
			J_LY: begin la = cy_q[0]; lb = cy_q[3]; end
			J_RX: begin la = cx_q[1]; lb = cx_q[2]; end
			J_RY: begin la = cy_q[1]; lb = cy_q[2]; end
			J_PX: begin la = lx_q; lb = rx_q; li = col_q; end
			J_PY: begin la = ly_q; lb = ry_q; li = col_q; end
			default: ;
		endcase
	end

	assign diff = 41'(lb) - 41'(la);
	assign lnum = ((diff * $signed(41'(li))) <<< 1) + $signed(41'(nn));

	always_comb begin
		num = lnum;
		den = 31'({nn, 1'b0});
		case (job_q)
			J_IX: begin num = 41'(px_q) - 41'(origin_x_q); den = res_eff; end
			J_IY: begin num = 41'(origin_y_q) - 41'(py_q); den = res_eff; end
			J_BL: begin num = bsum_q; den = 31'(7'(q_q) * 7'(q_q)); end
			default: ;
		endcase
		mag = num[40] ? DIV_W'(-num) : DIV_W'(num);
		if (job_q == J_BL)
			mag = mag + DIV_W'(den >> 1);
	end

	// divider step
	logic [31:0] rsh;
	logic        ge;
	assign rsh = {rem_q[30:0], dq_q[DIV_W-1]};
	assign ge  = (rsh >= {1'b0, vsr_q});

	// post-processing of the quotient
	logic signed [40:0] qext, fl, lres, sres;
	assign qext = $signed({1'b0, dq_q});
	assign fl   = neg_q ? -(qext + 41'(rem_q != 32'd0)) : qext;
	assign lres = 41'(la) + fl;
	assign sres = neg_q ? -qext : qext;

	logic oob_now, ix_neg, idx_over;
	assign ix_neg   = neg_q && (dq_q != '0);
	assign idx_over = (job_q == J_IX) ? (dq_q >= DIV_W'(wlim)) : (dq_q >= DIV_W'(hlim));
	assign oob_now  = oobx_q || ix_neg || idx_over;

	// nearest-quadrant value
	logic signed [31:0] near_val;
	logic               top_half, left_half;
	logic [QW-1:0]      half;
	assign half      = q_q >> 1;
	assign top_half  = row_q < half;
	assign left_half = col_q < half;
	always_comb begin
		if (top_half)
			near_val = left_half ? v_q[0] : v_q[1];
		else
			near_val = left_half ? v_q[3] : v_q[2];
	end

	// bilinear weights
	logic [QW-1:0] wx, wy, wxc, wyc;
	assign wx  = nn - col_q;
	assign wy  = nn - row_q;
	assign wxc = col_q + QW'(1);
	assign wyc = row_q + QW'(1);

	logic at_end;
	assign at_end = (row_q == nn) && (col_q == nn);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			job_q    <= J_LX;
			ovalid_q <= 1'b0;
			ecnt_q   <= '0;
			dcnt_q   <= '0;
			row_q    <= '0;
			col_q    <= '0;
			q_q      <= QW'(2);
			clamp_q  <= 1'b0;
			near_q   <= 1'b0;
			oobx_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cx_q[0] <= in_data.corner0_x; cy_q[0] <= in_data.corner0_y;
						cx_q[1] <= in_data.corner1_x; cy_q[1] <= in_data.corner1_y;
						cx_q[2] <= in_data.corner2_x; cy_q[2] <= in_data.corner2_y;
						cx_q[3] <= in_data.corner3_x; cy_q[3] <= in_data.corner3_y;
						v_q[0]  <= in_data.value0;
						v_q[1]  <= in_data.value1;
						v_q[2]  <= in_data.value2;
						v_q[3]  <= in_data.value3;
						near_q  <= !mode_q || (in_data.value0 == nodata_q) ||
							(in_data.value1 == nodata_q) || (in_data.value2 == nodata_q) ||
							(in_data.value3 == nodata_q);
						mw_q    <= '0;
						mh_q    <= '0;
						ecnt_q  <= '0;
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					// rotate the corner line; four steps restore the order
					if (ex_abs > mw_q) mw_q <= ex_abs;
					if (ey_abs > mh_q) mh_q <= ey_abs;
					for (int k = 0; k < 4; k++) begin
						cx_q[k] <= cx_q[(k + 1) % 4];
						cy_q[k] <= cy_q[(k + 1) % 4];
					end
					ecnt_q <= ecnt_q + 2'd1;
					if (ecnt_q == 2'd3) begin
						acc_q   <= 35'(res_eff);
						q_q     <= QW'(2);
						clamp_q <= 1'b0;
						state_q <= S_SIZE;
					end
				end
				S_SIZE: begin
					// q grows by one per multiple of resolution up to the span
					if (35'(mm) >= acc_q) begin
						if (q_q == QMAX) begin
							clamp_q <= 1'b1;
							row_q   <= '0;
							col_q   <= '0;
							job_q   <= J_LX;
							state_q <= S_LAUNCH;
						end else begin
							q_q   <= q_q + QW'(1);
							acc_q <= acc_q + 35'(res_eff);
						end
					end else begin
						row_q   <= '0;
						col_q   <= '0;
						job_q   <= J_LX;
						state_q <= S_LAUNCH;
					end
				end
				S_LAUNCH: begin
					dq_q    <= mag;
					vsr_q   <= den;
					neg_q   <= num[40];
					rem_q   <= '0;
					dcnt_q  <= DCNT_W'(DIV_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q  <= ge ? (rsh - {1'b0, vsr_q}) : rsh;
					dq_q   <= {dq_q[DIV_W-2:0], ge};
					dcnt_q <= dcnt_q - DCNT_W'(1);
					if (dcnt_q == '0)
						state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_LAUNCH;
					case (job_q)
						J_LX: begin lx_q <= lres[31:0]; job_q <= J_LY; end
						J_LY: begin ly_q <= lres[31:0]; job_q <= J_RX; end
						J_RX: begin rx_q <= lres[31:0]; job_q <= J_RY; end
						J_RY: begin ry_q <= lres[31:0]; job_q <= J_PX; end
						J_PX: begin px_q <= lres[31:0]; job_q <= J_PY; end
						J_PY: begin py_q <= lres[31:0]; job_q <= J_IX; end
						J_IX: begin
							ix_q   <= dq_q[14:0];
							oobx_q <= ix_neg || idx_over;
							job_q  <= J_IY;
						end
						J_IY: begin
							iy_q <= dq_q[14:0];
							if (oob_now) begin
								out_q.pixel_x       <= '0;
								out_q.pixel_y       <= '0;
								out_q.pixel_value   <= '0;
								out_q.last          <= 1'b1;
								out_q.out_of_bounds <= 1'b1;
								out_q.size_clamped  <= clamp_q;
								ovalid_q            <= 1'b1;
								state_q             <= S_OUT;
							end else if (near_q) begin
								out_q.pixel_x       <= ix_q;
								out_q.pixel_y       <= dq_q[14:0];
								out_q.pixel_value   <= near_val;
								out_q.last          <= at_end;
								out_q.out_of_bounds <= 1'b0;
								out_q.size_clamped  <= clamp_q;
								ovalid_q            <= 1'b1;
								state_q             <= S_OUT;
							end else begin
								state_q <= S_BTOP;
							end
						end
						default: begin
							out_q.pixel_x       <= ix_q;
							out_q.pixel_y       <= iy_q;
							out_q.pixel_value   <= sres[31:0];
							out_q.last          <= at_end;
							out_q.out_of_bounds <= 1'b0;
							out_q.size_clamped  <= clamp_q;
							ovalid_q            <= 1'b1;
							state_q             <= S_OUT;
						end
					endcase
				end
				S_BTOP: begin
					top_q   <= 37'(v_q[0] * $signed(37'(wx))) +
						37'(v_q[1] * $signed(37'(wxc)));
					state_q <= S_BBOT;
				end
				S_BBOT: begin
					bot_q   <= 37'(v_q[3] * $signed(37'(wx))) +
						37'(v_q[2] * $signed(37'(wxc)));
					state_q <= S_BSUM;
				end
				S_BSUM: begin
					bsum_q  <= 41'(top_q * $signed(41'(wy))) +
						41'(bot_q * $signed(41'(wyc)));
					job_q   <= J_BL;
					state_q <= S_LAUNCH;
				end
				S_OUT: begin
					if (out_ready) begin
						ovalid_q <= 1'b0;
						oobx_q   <= 1'b0;
						if (out_q.last) begin
							state_q <= S_IDLE;
						end else if (col_q == nn) begin
							col_q   <= '0;
							row_q   <= row_q + QW'(1);
							job_q   <= J_LX;
							state_q <= S_LAUNCH;
						end else begin
							col_q   <= col_q + QW'(1);
							job_q   <= J_PX;
							state_q <= S_LAUNCH;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("quad taken while a pixel is pending");
	a_oob_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.out_of_bounds) |-> out_data.last)
		else $error("out of bounds pixel not marked last");
	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!out_valid && !in_ready))
		else $error("quad accept did not start sizing");
	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_data.last) |=> in_ready)
		else $error("block not idle after final pixel");
`endif

endmodule
`default_nettype wire
